### design/rounded_rect_vertex_gen_macros.svh
// assertion macros for the rounded rectangle vertex generator
`ifndef ROUNDED_RECT_VERTEX_GEN_MACROS_SVH
`define ROUNDED_RECT_VERTEX_GEN_MACROS_SVH
`ifndef SYNTH
`define RRV_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rrv assertion failed");
`define RRV_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("rrv assertion failed");
`else
`define RRV_ASSERT(lbl, prop)
`define RRV_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### design/rrv_pkg.sv
package rrv_pkg;

   localparam int IDX_W = 6;
   localparam int LEN_W = 16;
   localparam int POS_W = 16;
   localparam int TEX_W = 17;
   localparam int CNT_W = 7;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int ANGLE_BITS_DEF   = 16;

   localparam int CORDIC_STEPS = 30;
   localparam int CX_W = 33;
   localparam int CZ_W = 34;
   localparam int CS_W = 18;
   localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

   typedef enum logic [1:0] {
      CSR_RADIUS,
      CSR_WIDTH,
      CSR_HEIGHT,
      CSR_COUNT
   } csr_index_type;

   typedef enum logic [1:0] {
      XS_PLUS,
      XS_MINUS,
      XS_NONE
   } x_side_type;

   typedef struct packed {
      logic       err;
      logic       last;
      x_side_type xs;
      logic       y_plus;
      logic [1:0] quad;
   } side_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CZ_W-1:0] z;
   } cordic_type;

   // derived shape values, to be kept constant by the user while items flow; the block does not enforce it
   typedef struct packed {
      logic [LEN_W-1:0] radius;
      logic [LEN_W-1:0] half_x;
      logic [LEN_W-1:0] half_y;
      logic [TEX_W-1:0] u_factor;
      logic [TEX_W-1:0] v_factor;
   } shape_type;

   // atan(2^-k) in units of 2^32 per turn
   function automatic logic [CZ_W-1:0] atan_turn(input int k);
      unique case (k)
         0:  return 34'd536870912;
         1:  return 34'd316933406;
         2:  return 34'd167458907;
         3:  return 34'd85004756;
         4:  return 34'd42667331;
         5:  return 34'd21354465;
         6:  return 34'd10679838;
         7:  return 34'd5340245;
         8:  return 34'd2670163;
         9:  return 34'd1335087;
         10: return 34'd667544;
         11: return 34'd333772;
         12: return 34'd166886;
         13: return 34'd83443;
         14: return 34'd41722;
         15: return 34'd20861;
         16: return 34'd10430;
         17: return 34'd5215;
         18: return 34'd2608;
         19: return 34'd1304;
         20: return 34'd652;
         21: return 34'd326;
         22: return 34'd163;
         23: return 34'd81;
         24: return 34'd41;
         25: return 34'd20;
         26: return 34'd10;
         27: return 34'd5;
         28: return 34'd3;
         29: return 34'd1;
         default: return '0;
      endcase
   endfunction

endpackage

### design/rrv_cordic_cell.sv
module rrv_cordic_cell
   import rrv_pkg::*;
#(
   parameter int K = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  cordic_type in_data,
   input  side_type   in_side,
   output logic       ready_up,
   input  logic       ready_dn,
   output logic       out_valid,
   output cordic_type out_data,
   output side_type   out_side
);

   logic signed [CX_W-1:0] x;
   logic signed [CX_W-1:0] y;
   logic signed [CZ_W-1:0] z;
   logic signed [CX_W-1:0] dx;
   logic signed [CX_W-1:0] dy;
   logic signed [CZ_W-1:0] step;
   cordic_type             data_in;
   logic                   valid_ff;
   cordic_type             data_ff;
   side_type               side_ff;

   assign ready_up = !valid_ff || ready_dn;

   // one micro-rotation, direction from the sign of the residual angle
   always_comb begin
      x    = in_data.x;
      y    = in_data.y;
      z    = in_data.z;
      dx   = y >>> K;
      dy   = x >>> K;
      step = signed'(atan_turn(K));
      if (!z[CZ_W-1]) begin
         data_in.x = x - dx;
         data_in.y = y + dy;
         data_in.z = z - step;
      end else begin
         data_in.x = x + dx;
         data_in.y = y - dy;
         data_in.z = z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_up) begin
         valid_ff <= in_valid;
      end
      if (ready_up && in_valid) begin
         data_ff <= data_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_side  = side_ff;

endmodule

### design/rrv_derive.sv
module rrv_derive
   import rrv_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
   parameter int NW           = $clog2(MAX_VERTICES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [LEN_W-1:0]      csr_data,
   output shape_type             shape,
   output logic [ANGLE_BITS-1:0] turn_step,
   output logic [NW-1:0]         count,
   output logic                  busy
);

   localparam int DEN_W = LEN_W + 1;
   localparam int NUM_W = 2 * LEN_W + 1;
   localparam int STEPS = NUM_W;
   localparam int SC_W  = $clog2(STEPS + 1);
   localparam int RESET_N = (64 < 3) ? 3 : ((64 > MAX_VERTICES) ? MAX_VERTICES : 64);
   localparam int RESET_TURN = ((1 << ANGLE_BITS) + RESET_N / 2) / RESET_N;

   typedef enum logic [1:0] {S_IDLE, S_LOAD, S_STEP, S_STORE} state_type;
   typedef enum logic [1:0] {JOB_U, JOB_V, JOB_T} job_type;

   state_type               state_ff;
   job_type                 job_ff;
   logic [LEN_W-1:0]        radius_cfg_ff;
   logic [LEN_W-1:0]        width_ff;
   logic [LEN_W-1:0]        height_ff;
   logic [CNT_W-1:0]        count_cfg_ff;
   logic [TEX_W-1:0]        u_ff;
   logic [TEX_W-1:0]        v_ff;
   logic [ANGLE_BITS-1:0]   turn_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [DEN_W-1:0]        rem_ff;
   logic [SC_W-1:0]         step_ff;
   logic                    zero_ff;

   logic [31:0]             cnt_w;
   logic [31:0]             n32;
   logic [DEN_W-1:0]        r2;
   logic [DEN_W-1:0]        m17;
   logic [LEN_W-1:0]        m;
   logic [LEN_W-1:0]        len;
   logic [DEN_W-1:0]        den_in;
   logic [NUM_W-1:0]        num_in;
   logic [DEN_W:0]          rem_sh;
   logic                    ge;
   logic [DEN_W:0]          rem_sub;
   logic                    wr;

   assign wr = csr_valid && csr_ready;

   // effective vertex count and clamped radius
   always_comb begin
      cnt_w = 32'(count_cfg_ff);
      if (cnt_w < 32'd3) begin
         n32 = 32'd3;
      end else if (cnt_w > 32'(MAX_VERTICES)) begin
         n32 = 32'(MAX_VERTICES);
      end else begin
         n32 = cnt_w;
      end
      r2  = {radius_cfg_ff, 1'b0};
      m17 = r2;
      if ({1'b0, width_ff} < m17) begin
         m17 = {1'b0, width_ff};
      end
      if ({1'b0, height_ff} < m17) begin
         m17 = {1'b0, height_ff};
      end
      m = m17[LEN_W-1:0];
   end

   // dividend and divisor for the current job
   always_comb begin
      len = (job_ff == JOB_V) ? height_ff : width_ff;
      if (job_ff == JOB_T) begin
         den_in = DEN_W'(n32[NW-1:0]);
         num_in = (NUM_W'(1) << ANGLE_BITS) + NUM_W'(n32[NW-1:1]);
      end else begin
         den_in = DEN_W'(len) + DEN_W'(m);
         num_in = {1'b0, len - m, {LEN_W{1'b0}}} + NUM_W'(den_in[DEN_W-1:1]);
      end
   end

   // restoring divider step
   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         job_ff        <= JOB_U;
         radius_cfg_ff <= LEN_W'(256);
         width_ff      <= LEN_W'(256);
         height_ff     <= LEN_W'(256);
         count_cfg_ff  <= CNT_W'(64);
         u_ff          <= '0;
         v_ff          <= '0;
         turn_ff       <= ANGLE_BITS'(RESET_TURN);
         step_ff       <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (wr) begin
                  unique case (csr_index_type'(csr_index))
                     CSR_RADIUS: radius_cfg_ff <= csr_data;
                     CSR_WIDTH:  width_ff      <= csr_data;
                     CSR_HEIGHT: height_ff     <= csr_data;
                     CSR_COUNT:  count_cfg_ff  <= csr_data[CNT_W-1:0];
                  endcase
                  job_ff   <= JOB_U;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               den_ff   <= den_in;
               num_ff   <= num_in;
               rem_ff   <= '0;
               zero_ff  <= den_in == '0;
               step_ff  <= '0;
               state_ff <= S_STEP;
            end
            S_STEP: begin
               rem_ff  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
               num_ff  <= {num_ff[NUM_W-2:0], ge};
               step_ff <= step_ff + 1'b1;
               if (step_ff == SC_W'(STEPS - 1)) begin
                  state_ff <= S_STORE;
               end
            end
            S_STORE: begin
               unique case (job_ff)
                  JOB_U: begin
                     u_ff     <= zero_ff ? '0 : num_ff[TEX_W-1:0];
                     job_ff   <= JOB_V;
                     state_ff <= S_LOAD;
                  end
                  JOB_V: begin
                     v_ff     <= zero_ff ? '0 : num_ff[TEX_W-1:0];
                     job_ff   <= JOB_T;
                     state_ff <= S_LOAD;
                  end
                  JOB_T: begin
                     turn_ff  <= num_ff[ANGLE_BITS-1:0];
                     state_ff <= S_IDLE;
                  end
                  default: begin
                     state_ff <= S_IDLE;
                  end
               endcase
            end
         endcase
      end
   end

   assign csr_ready       = !reset && state_ff == S_IDLE;
   assign busy            = state_ff != S_IDLE;
   assign shape.radius    = m;
   assign shape.half_x    = width_ff - m;
   assign shape.half_y    = height_ff - m;
   assign shape.u_factor  = u_ff;
   assign shape.v_factor  = v_ff;
   assign turn_step       = turn_ff;
   assign count           = n32[NW-1:0];

endmodule

### design/rounded_rect_vertex_gen.sv
// rounded rectangle vertex generator: for a vertex index i of an n-vertex
// outline it returns the point at angle 2*pi*i/n on the clamped corner circle,
// shifted by the inner half extents per quadrant, plus a Q1.16 texture
// coordinate (v flipped). one item per cycle sustained when the receiver does
// not stall and no divisions run; each item passes an input register, a row
// of 30 cordic cells (one micro-rotation each), two stages (round and unfold,
// multiply) and the output register, which takes the offset and saturate
// logic. after every register write the block runs three serial divisions
// (two shape factors and the phase step), and the csr port and the item input
// hold off until they finish. the item input is also held off during reset.
`include "rounded_rect_vertex_gen_macros.svh"
module rounded_rect_vertex_gen
   import rrv_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [LEN_W-1:0]        csr_data,
   // input items
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [IDX_W-1:0]        req_vertex_index,
   // result items
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [POS_W-1:0] rsp_pos_x,
   output logic signed [POS_W-1:0] rsp_pos_y,
   output logic [TEX_W-1:0]        rsp_tex_u,
   output logic [TEX_W-1:0]        rsp_tex_v,
   output logic                    rsp_is_last,
   output logic                    rsp_index_error
);

   localparam int NW = $clog2(MAX_VERTICES + 1);
   localparam int CW = NW + 9;
   localparam int PX_W = 37;
   localparam int NU_W = 38;
   localparam logic signed [CX_W-1:0] ONE_C   = CX_W'(65536);
   localparam logic signed [CX_W-1:0] M_ONE_C = -CX_W'(65536);
   localparam logic signed [PX_W-1:0] POS_MAX = PX_W'(32767);
   localparam logic signed [PX_W-1:0] POS_MIN = -PX_W'(32768);
   localparam logic signed [NU_W-1:0] TEX_MAX = NU_W'(65536);
   localparam logic signed [NU_W-1:0] TEX_BIAS = NU_W'(64'h2_0002_0000);

   shape_type             shape;
   logic [ANGLE_BITS-1:0] turn_step;
   logic [NW-1:0]         count;
   logic                  busy;

   rrv_derive #(
      .MAX_VERTICES (MAX_VERTICES),
      .ANGLE_BITS   (ANGLE_BITS),
      .NW           (NW)
   ) u_derive (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .shape     (shape),
      .turn_step (turn_step),
      .count     (count),
      .busy      (busy)
   );

   // ---------------- input stage: quadrant tests and phase ----------------
   logic [CW-1:0]                 i_w;
   logic [CW-1:0]                 n_w;
   logic [ANGLE_BITS+IDX_W-1:0]   phase_full;
   side_type                      side_in;
   logic                          s0_v_ff;
   logic [ANGLE_BITS-1:0]         s0_phase_ff;
   side_type                      s0_side_ff;
   logic                          s0_rdy;

   always_comb begin
      i_w        = CW'(req_vertex_index);
      n_w        = CW'(count);
      phase_full = (ANGLE_BITS+IDX_W)'(turn_step) * (ANGLE_BITS+IDX_W)'(req_vertex_index);
      side_in.err    = i_w >= n_w;
      side_in.last   = i_w == n_w - 1'b1;
      side_in.y_plus = (i_w << 1) < n_w;
      side_in.quad   = '0;
      // quarter turn exactly: no horizontal shift
      if ((i_w << 2) < n_w || (i_w << 2) > 3 * n_w) begin
         side_in.xs = XS_PLUS;
      end else if ((i_w << 2) > n_w) begin
         side_in.xs = XS_MINUS;
      end else begin
         side_in.xs = XS_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (s0_rdy) begin
         s0_v_ff <= req_valid && !req_stall;
      end
      if (s0_rdy && req_valid && !req_stall) begin
         s0_phase_ff <= phase_full[ANGLE_BITS-1:0];
         s0_side_ff  <= side_in;
      end
   end

   // octant fold: quadrant from the rounded top bits, residual signed
   logic [31:0] p32;
   logic [31:0] p_bias;
   logic [1:0]  quad;
   logic [31:0] resid;

   always_comb begin
      p32    = {s0_phase_ff, {(32-ANGLE_BITS){1'b0}}};
      p_bias = p32 + 32'h2000_0000;
      quad   = p_bias[31:30];
      resid  = p32 - {quad, 30'b0};
   end

   // ---------------- cordic cell row ----------------
   cordic_type chain_d [0:CORDIC_STEPS];
   side_type   chain_s [0:CORDIC_STEPS];
   logic       chain_v [0:CORDIC_STEPS];
   logic       chain_rdy [0:CORDIC_STEPS];

   // head of the row: gain-scaled unit vector and the residual angle
   assign chain_d[0] = {CX_W'(CORDIC_GAIN), {CX_W{1'b0}}, {{(CZ_W-32){resid[31]}}, resid}};
   assign chain_s[0] = {s0_side_ff.err, s0_side_ff.last, s0_side_ff.xs,
                        s0_side_ff.y_plus, quad};
   assign chain_v[0] = s0_v_ff;

   assign s0_rdy    = !s0_v_ff || chain_rdy[0];
   assign req_stall = reset || busy || !s0_rdy;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      rrv_cordic_cell #(
         .K (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_v[k]),
         .in_data   (chain_d[k]),
         .in_side   (chain_s[k]),
         .ready_up  (chain_rdy[k]),
         .ready_dn  (chain_rdy[k+1]),
         .out_valid (chain_v[k+1]),
         .out_data  (chain_d[k+1]),
         .out_side  (chain_s[k+1])
      );
   end

   // ---------------- stage f1: round to q1.16, clamp, unfold ----------------
   logic signed [CX_W-1:0] xr;
   logic signed [CX_W-1:0] yr;
   logic signed [CS_W-1:0] c0;
   logic signed [CS_W-1:0] s0c;
   logic signed [CS_W-1:0] c_in;
   logic signed [CS_W-1:0] s_in;
   logic                   f1_v_ff;
   logic signed [CS_W-1:0] f1_c_ff;
   logic signed [CS_W-1:0] f1_s_ff;
   side_type               f1_side_ff;
   logic                   f1_rdy;
   logic                   f2_rdy;

   always_comb begin
      xr = (chain_d[CORDIC_STEPS].x + CX_W'(8192)) >>> 14;
      yr = (chain_d[CORDIC_STEPS].y + CX_W'(8192)) >>> 14;
      if (xr > ONE_C) begin
         c0 = CS_W'(65536);
      end else if (xr < M_ONE_C) begin
         c0 = -CS_W'(65536);
      end else begin
         c0 = xr[CS_W-1:0];
      end
      if (yr > ONE_C) begin
         s0c = CS_W'(65536);
      end else if (yr < M_ONE_C) begin
         s0c = -CS_W'(65536);
      end else begin
         s0c = yr[CS_W-1:0];
      end
      unique case (chain_s[CORDIC_STEPS].quad)
         2'd0: begin c_in = c0;   s_in = s0c;  end
         2'd1: begin c_in = -s0c; s_in = c0;   end
         2'd2: begin c_in = -c0;  s_in = -s0c; end
         2'd3: begin c_in = s0c;  s_in = -c0;  end
      endcase
   end

   assign chain_rdy[CORDIC_STEPS] = f1_rdy;
   assign f1_rdy = !f1_v_ff || f2_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else if (f1_rdy) begin
         f1_v_ff <= chain_v[CORDIC_STEPS];
      end
      if (f1_rdy && chain_v[CORDIC_STEPS]) begin
         f1_c_ff    <= c_in;
         f1_s_ff    <= s_in;
         f1_side_ff <= chain_s[CORDIC_STEPS];
      end
   end

   // ---------------- stage f2: products ----------------
   logic signed [CS_W-1:0]   r_s;
   logic signed [CS_W-1:0]   om_u;
   logic signed [CS_W-1:0]   om_v;
   logic                     f2_v_ff;
   logic signed [2*CS_W-1:0] f2_px_ff;
   logic signed [2*CS_W-1:0] f2_py_ff;
   logic signed [2*CS_W-1:0] f2_mu_ff;
   logic signed [2*CS_W-1:0] f2_mv_ff;
   logic signed [CS_W-1:0]   f2_c_ff;
   side_type                 f2_side_ff;
   logic                     out_rdy;

   assign r_s  = CS_W'(shape.radius);
   assign om_u = CS_W'(65536) - CS_W'(shape.u_factor);
   assign om_v = CS_W'(65536) - CS_W'(shape.v_factor);
   assign f2_rdy = !f2_v_ff || out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_v_ff <= 1'b0;
      end else if (f2_rdy) begin
         f2_v_ff <= f1_v_ff;
      end
      if (f2_rdy && f1_v_ff) begin
         f2_px_ff   <= f1_c_ff * r_s;
         f2_py_ff   <= f1_s_ff * r_s;
         f2_mu_ff   <= f1_c_ff * om_u;
         f2_mv_ff   <= f1_s_ff * om_v;
         f2_c_ff    <= f1_c_ff;
         f2_side_ff <= f1_side_ff;
      end
   end

   // ---------------- stage f3: offsets, rounding, saturation ----------------
   logic signed [PX_W-1:0] hx_o;
   logic signed [PX_W-1:0] hy_o;
   logic signed [PX_W-1:0] px;
   logic signed [PX_W-1:0] py;
   logic signed [PX_W-1:0] pxr;
   logic signed [PX_W-1:0] pyr;
   logic signed [NU_W-1:0] fu_o;
   logic signed [NU_W-1:0] fv_o;
   logic signed [NU_W-1:0] nu;
   logic signed [NU_W-1:0] nv;
   logic signed [NU_W-1:0] tu;
   logic signed [NU_W-1:0] tv;
   logic signed [POS_W-1:0] pos_x_in;
   logic signed [POS_W-1:0] pos_y_in;
   logic [TEX_W-1:0]        tex_u_in;
   logic [TEX_W-1:0]        tex_v_in;
   logic                    rsp_valid_ff;
   logic signed [POS_W-1:0] pos_x_ff;
   logic signed [POS_W-1:0] pos_y_ff;
   logic [TEX_W-1:0]        tex_u_ff;
   logic [TEX_W-1:0]        tex_v_ff;
   logic                    last_ff;
   logic                    err_ff;

   always_comb begin
      hx_o = PX_W'(shape.half_x) <<< 16;
      hy_o = PX_W'(shape.half_y) <<< 16;
      fu_o = NU_W'(shape.u_factor) <<< 17;
      fv_o = NU_W'(shape.v_factor) <<< 17;
      px   = PX_W'(f2_px_ff);
      py   = PX_W'(f2_py_ff);
      unique case (f2_side_ff.xs)
         XS_PLUS: begin
            px = px + hx_o;
            nu = fu_o + NU_W'(f2_mu_ff);
         end
         XS_MINUS: begin
            px = px - hx_o;
            nu = NU_W'(f2_mu_ff) - fu_o;
         end
         default: begin
            // quarter turn: unshifted, u from the cosine alone
            nu = NU_W'(f2_c_ff) <<< 17;
         end
      endcase
      if (f2_side_ff.y_plus) begin
         py = py + hy_o;
         nv = fv_o + NU_W'(f2_mv_ff);
      end else begin
         py = py - hy_o;
         nv = NU_W'(f2_mv_ff) - fv_o;
      end
      // round half up by 2^17, then saturate
      pxr = (px + PX_W'(65536)) >>> 17;
      pyr = (py + PX_W'(65536)) >>> 17;
      if (pxr > POS_MAX) begin
         pos_x_in = 16'sh7fff;
      end else if (pxr < POS_MIN) begin
         pos_x_in = -16'sh8000;
      end else begin
         pos_x_in = pxr[POS_W-1:0];
      end
      if (pyr > POS_MAX) begin
         pos_y_in = 16'sh7fff;
      end else if (pyr < POS_MIN) begin
         pos_y_in = -16'sh8000;
      end else begin
         pos_y_in = pyr[POS_W-1:0];
      end
      // texture: (n + 2^33) / 2^18 rounded half up, clamped to [0, 1]
      tu = (nu + TEX_BIAS) >>> 18;
      tv = (nv + TEX_BIAS) >>> 18;
      if (tu < 0) begin
         tex_u_in = '0;
      end else if (tu > TEX_MAX) begin
         tex_u_in = TEX_W'(65536);
      end else begin
         tex_u_in = tu[TEX_W-1:0];
      end
      if (tv < 0) begin
         tex_v_in = TEX_W'(65536);
      end else if (tv > TEX_MAX) begin
         tex_v_in = '0;
      end else begin
         tex_v_in = TEX_W'(65536) - tv[TEX_W-1:0];
      end
   end

   // output register, released as soon as the item is taken
   assign out_rdy = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= f2_v_ff;
      end
      if (out_rdy && f2_v_ff) begin
         if (f2_side_ff.err) begin
            // index out of range: all fields zero but the flag
            pos_x_ff <= '0;
            pos_y_ff <= '0;
            tex_u_ff <= '0;
            tex_v_ff <= '0;
            last_ff  <= 1'b0;
         end else begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
            tex_u_ff <= tex_u_in;
            tex_v_ff <= tex_v_in;
            last_ff  <= f2_side_ff.last;
         end
         err_ff <= f2_side_ff.err;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_tex_u       = tex_u_ff;
   assign rsp_tex_v       = tex_v_ff;
   assign rsp_is_last     = last_ff;
   assign rsp_index_error = err_ff;

   // checks
   `RRV_ASSERT(a_err_zero, (rsp_valid && rsp_index_error) |-> (rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_tex_u == '0 && rsp_tex_v == '0 && !rsp_is_last))
   `RRV_ASSERT(a_tex_range, rsp_valid |-> (rsp_tex_u <= 17'd65536 && rsp_tex_v <= 17'd65536))
   `RRV_ASSERT_NEXT(a_cfg_hold, csr_valid && csr_ready, !csr_ready && req_stall)

endmodule

### test/rounded_rect_vertex_gen_checker.sv
module rounded_rect_vertex_gen_checker
   import rrv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [LEN_W-1:0]        csr_data,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [IDX_W-1:0]        req_vertex_index,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [POS_W-1:0] rsp_pos_x,
   input  logic signed [POS_W-1:0] rsp_pos_y,
   input  logic [TEX_W-1:0]        rsp_tex_u,
   input  logic [TEX_W-1:0]        rsp_tex_v,
   input  logic                    rsp_is_last,
   input  logic                    rsp_index_error,
   output int                      fail_count,
   output int                      vertices_due,
   output int                      vertices_seen,
   output int                      error_flags_seen
);

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
      logic             is_last;
      logic             index_error;
   } vertex_type;

   localparam longint HALF_TURN_Q17 = 131072;
   localparam longint ONE = 65536;

   logic [LEN_W-1:0] cfg_radius, cfg_width, cfg_height;
   logic [CNT_W-1:0] cfg_count;
   vertex_type       vertex_queue[$];

   function automatic longint round_div(longint num, longint den);
      longint m, q;
      m = num + den / 2;
      q = m / den;
      if (m % den != 0 && m < 0)
         q--;
      return q;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v > hi) ? hi : (v < lo) ? lo : v;
   endfunction

   function automatic longint factor_of(longint len, longint r2);
      if (len + r2 == 0)
         return 0;
      return (((len - r2) << 16) + (len + r2) / 2) / (len + r2);
   endfunction

   function automatic longint tex_from(longint num);
      return clip(round_div(num + ONE * HALF_TURN_Q17, 262144), 0, ONE);
   endfunction

   // cosine and sine in Q1.16 of a 32-bit turn angle
   function automatic void cos_sin(logic [31:0] p, output longint co, output longint si);
      logic [31:0] q, r;
      longint x, y, z, dx, dy, c, s;
      q = ((p + 32'h2000_0000) >> 30) & 32'd3;
      r = p - (q << 30);
      z = longint'($signed(r));
      x = CORDIC_GAIN;
      y = 0;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_turn(k));
         end else begin
            x += dx; y -= dy; z += longint'(atan_turn(k));
         end
      end
      c = clip(round_div(x, 16384), -ONE, ONE);
      s = clip(round_div(y, 16384), -ONE, ONE);
      case (q[1:0])
         2'd0: begin co = c; si = s; end
         2'd1: begin co = -s; si = c; end
         2'd2: begin co = -c; si = -s; end
         default: begin co = s; si = -c; end
      endcase
   endfunction

   function automatic vertex_type outline_vertex(logic [IDX_W-1:0] idx);
      vertex_type v;
      longint n, i, m, fx, fy, hx, hy, stp, c, s, px, py, nu, nv;
      logic [31:0] phase;
      v = '0;
      n = (cfg_count < 3) ? 3 : (cfg_count > 64) ? 64 : cfg_count;
      i = idx;
      if (i >= n) begin
         v.index_error = 1'b1;
         return v;
      end
      m = longint'(cfg_radius) * 2;
      if (cfg_width < m) m = cfg_width;
      if (cfg_height < m) m = cfg_height;
      fx = factor_of(cfg_width, m);
      fy = factor_of(cfg_height, m);
      hx = longint'(cfg_width) - m;
      hy = longint'(cfg_height) - m;
      stp = (ONE + n / 2) / n;
      phase = 32'((i * stp) & 16'hFFFF) << 16;
      cos_sin(phase, c, s);
      px = c * m;
      py = s * m;
      if (4 * i < n || 4 * i > 3 * n) begin
         px += hx * ONE;
         nu = fx * HALF_TURN_Q17 + (ONE - fx) * c;
      end else if (4 * i > n) begin
         px -= hx * ONE;
         nu = -fx * HALF_TURN_Q17 + (ONE - fx) * c;
      end else begin
         // exact quarter turn: no horizontal shift
         nu = c * HALF_TURN_Q17;
      end
      if (2 * i < n) begin
         py += hy * ONE;
         nv = fy * HALF_TURN_Q17 + (ONE - fy) * s;
      end else begin
         py -= hy * ONE;
         nv = -fy * HALF_TURN_Q17 + (ONE - fy) * s;
      end
      v.pos_x = POS_W'(clip(round_div(px, HALF_TURN_Q17), -32768, 32767));
      v.pos_y = POS_W'(clip(round_div(py, HALF_TURN_Q17), -32768, 32767));
      v.tex_u = TEX_W'(tex_from(nu));
      v.tex_v = TEX_W'(ONE - tex_from(nv));
      v.is_last = (i == n - 1);
      return v;
   endfunction

   always @(posedge clock) begin
      vertex_type want, got;
      if (reset) begin
         cfg_radius <= 16'd256;
         cfg_width <= 16'd256;
         cfg_height <= 16'd256;
         cfg_count <= 7'd64;
         vertex_queue.delete();
         fail_count <= 0;
         vertices_seen <= 0;
         error_flags_seen <= 0;
         vertices_due <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_RADIUS: cfg_radius <= csr_data;
               CSR_WIDTH:  cfg_width <= csr_data;
               CSR_HEIGHT: cfg_height <= csr_data;
               CSR_COUNT:  cfg_count <= csr_data[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            vertex_queue.insert(vertex_queue.size(), outline_vertex(req_vertex_index));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_pos_x, rsp_pos_y, rsp_tex_u, rsp_tex_v, rsp_is_last, rsp_index_error};
            vertices_seen <= vertices_seen + 1;
            if (rsp_index_error)
               error_flags_seen <= error_flags_seen + 1;
            if (vertex_queue.size() == 0) begin
               $display("%0t: unexpected vertex %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = vertex_queue.pop_front();
               if (want !== got) begin
                  $display("%0t: mismatch x %0d/%0d y %0d/%0d u %0d/%0d v %0d/%0d last %b/%b err %b/%b (expected/actual)",
                     $time, $signed(want.pos_x), rsp_pos_x, $signed(want.pos_y), rsp_pos_y,
                     want.tex_u, rsp_tex_u, want.tex_v, rsp_tex_v,
                     want.is_last, rsp_is_last, want.index_error, rsp_index_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // items still owed by the block after this edge
         vertices_due <= vertex_queue.size();
      end
   end

endmodule

### test/rounded_rect_vertex_gen_test.sv
module rounded_rect_vertex_gen_test;
   import rrv_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [1:0]              csr_index = CSR_RADIUS;
   logic [LEN_W-1:0]        csr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [IDX_W-1:0]        req_vertex_index = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_pos_x, rsp_pos_y;
   logic [TEX_W-1:0]        rsp_tex_u, rsp_tex_v;
   logic                    rsp_is_last, rsp_index_error;

   int fail_count, vertices_due, vertices_seen, error_flags_seen;

   // idling percentages for the two sides, set per phase
   int send_idle_pct = 0;
   int stall_pct = 0;
   // pulse that starts the long receiver hold
   logic hold_go = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;
   int   count_eff = 64;
   int   configs_run = 0;

   rounded_rect_vertex_gen uut (.*);

   rounded_rect_vertex_gen_checker check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stalls plus an occasional long hold
   always @(posedge clock) begin
      if (hold_go && hold_left == 0) begin
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog: cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("rounded_rect_vertex_gen_test: FAIL");
         $finish;
      end
   end

   // offer one vertex index, with random idle cycles before it
   task automatic send_vertex(input logic [IDX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_index <= idx;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // wait until the pipeline has drained, then let the last items settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (vertices_due != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [LEN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_shape(input logic [15:0] r, w, h, input logic [6:0] n);
      drain();
      write_reg(CSR_RADIUS, r);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_COUNT, {9'd0, n});
      count_eff = (n < 3) ? 3 : (n > 64) ? 64 : n;
      configs_run++;
   endtask

   // mostly indices inside the outline, some past the end
   function automatic logic [IDX_W-1:0] pick_index();
      if ($urandom_range(99) < 85)
         return IDX_W'($urandom_range(count_eff - 1));
      return IDX_W'($urandom_range(63));
   endfunction

   initial begin
      logic [IDX_W-1:0] corner_idx[] = '{0, 63, 16, 32, 48, 1, 15, 17, 31, 33, 47, 49,
                                          8, 24, 40, 56, 62, 21, 42};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset shape, axis crossings, quarter turns, last vertex
      foreach (corner_idx[k])
         send_vertex(corner_idx[k]);

      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: set_shape(16'd0, 16'd0, 16'd0, 7'd3);
            1: set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd64);
            2: set_shape(16'd256, 16'd1024, 16'd512, 7'd127);
            3: set_shape(16'd100, 16'hFFFF, 16'd10, 7'd0);
            4: set_shape(16'hFFFF, 16'd0, 16'hFFFF, 7'd4);
            5: set_shape(16'd1, 16'hFFFF, 16'hFFFF, 7'd65);
            default: set_shape(16'($urandom), 16'($urandom), 16'($urandom),
                               7'($urandom_range(3, 64)));
         endcase
         // idling mode rotates: none, sender, receiver, both
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 80; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 80; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         // long receiver hold with a busy sender fills the pipeline
         if (phase == 1 || phase == 8) begin
            hold_go <= 1'b1;
            send_vertex(pick_index());
            hold_go <= 1'b0;
         end
         if (phase == 4 || phase == 0)
            for (int k = 0; k < 64; k++)
               send_vertex(IDX_W'(k));
         for (int k = 0; k < 90; k++)
            send_vertex(pick_index());
      end

      drain();
      $display("covered %0d shape settings, %0d vertices checked, %0d past the outline end",
               configs_run, vertices_seen, error_flags_seen);
      if (fail_count == 0)
         $display("rounded_rect_vertex_gen_test: PASS");
      else
         $display("rounded_rect_vertex_gen_test: FAIL");
      $finish;
   end

endmodule
